// ===== hw/rtl/svcf_pkg.sv =====
// Package for the servo command packet framer.
// Holds command codes, packet constants, the control word layout and the microcode ROM.
// No dependencies; svcf_seq and the top level import it.
package svcf_pkg;

    // Command kinds as carried on the command channel.
    typedef enum logic [1:0]
    {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_PING  = 2'd2,
        FUNC_RESET = 2'd3
    } func_t;

    // Fixed packet bytes.
    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] INS_PING   = 8'h01;
    localparam logic [7:0] INS_READ   = 8'h02;
    localparam logic [7:0] INS_WRITE  = 8'h03;
    localparam logic [7:0] INS_RESET  = 8'h06;
    localparam logic [7:0] LEN_SHORT  = 8'h02;
    localparam logic [7:0] LEN_MID    = 8'h04;
    localparam logic [7:0] LEN_LONG   = 8'h05;
    localparam logic [1:0] CNT_TWO    = 2'd2;

    // Step counter of the sequencer.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // Step numbers that the program jumps to.
    localparam step_t STEP_FIRST = 4'd0;
    localparam step_t STEP_CHK   = 4'd8;

    // Where the byte of a step comes from.
    typedef enum logic [2:0]
    {
        SRC_HDR,
        SRC_ID,
        SRC_LEN,
        SRC_INS,
        SRC_ADDR,
        SRC_P1,
        SRC_HI,
        SRC_CHK
    } src_t;

    // Jump condition evaluated at the end of a step.
    typedef enum logic [1:0]
    {
        JMP_NONE,
        JMP_NO_PARAM,
        JMP_NO_HI,
        JMP_END
    } jmp_t;

    // One control word of the program.
    typedef struct packed
    {
        src_t  src;
        logic  add_sum;
        logic  chk;
        jmp_t  jmp;
        step_t target;
    } ctrl_word_t;

    // Conditions that the datapath hands to the sequencer.
    typedef struct packed
    {
        logic no_param;
        logic no_hi;
        logic more;
    } cond_t;

    // The framing program: two headers, id, length, instruction, up to three
    // parameters and the checksum, which loops back for a second copy.
    function automatic ctrl_word_t ucode_rom(input step_t pc);
        ctrl_word_t w;
        begin
            w = '{src: SRC_HDR, add_sum: 1'b0, chk: 1'b0, jmp: JMP_NONE, target: STEP_FIRST};
            case (pc)
                4'd0: w = '{SRC_HDR,  1'b0, 1'b0, JMP_NONE,     STEP_FIRST};
                4'd1: w = '{SRC_HDR,  1'b0, 1'b0, JMP_NONE,     STEP_FIRST};
                4'd2: w = '{SRC_ID,   1'b1, 1'b0, JMP_NONE,     STEP_FIRST};
                4'd3: w = '{SRC_LEN,  1'b1, 1'b0, JMP_NONE,     STEP_FIRST};
                4'd4: w = '{SRC_INS,  1'b1, 1'b0, JMP_NO_PARAM, STEP_CHK};
                4'd5: w = '{SRC_ADDR, 1'b1, 1'b0, JMP_NONE,     STEP_FIRST};
                4'd6: w = '{SRC_P1,   1'b1, 1'b0, JMP_NO_HI,    STEP_CHK};
                4'd7: w = '{SRC_HI,   1'b1, 1'b0, JMP_NONE,     STEP_FIRST};
                4'd8: w = '{SRC_CHK,  1'b0, 1'b1, JMP_END,      STEP_FIRST};
                default: w = '{SRC_CHK, 1'b0, 1'b1, JMP_END,    STEP_FIRST};
            endcase
            return w;
        end
    endfunction

endpackage

// ===== hw/rtl/svcf_intf.sv =====
// Handshake interfaces of the servo command packet framer: command channel and byte channel.
// Depends on nothing; each carries valid, ready and its payload.
interface svcf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  servo_id;
    logic [7:0]  reg_addr;
    logic [15:0] value;
    logic [1:0]  byte_count;

    modport source (output valid, func, servo_id, reg_addr, value, byte_count, input ready);
    modport sink   (input valid, func, servo_id, reg_addr, value, byte_count, output ready);
endinterface

interface svcf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       last;

    modport source (output valid, tx_byte, frame_end, last, input ready);
    modport sink   (input valid, tx_byte, frame_end, last, output ready);
endinterface

// ===== hw/rtl/svcf_seq.sv =====
// Microcode sequencer of the servo command packet framer: step counter, ROM and jump logic.
// Depends on svcf_pkg for the control word, the conditions and the program.
module svcf_seq
    import svcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       advance,
    input  cond_t      cond,
    output ctrl_word_t ctrl,
    output logic       busy
);

    step_t pc_reg;
    step_t pc_next;
    logic  busy_reg;
    logic  busy_next;

    // Current control word straight from the ROM.
    assign ctrl = ucode_rom(pc_reg);
    assign busy = busy_reg;

    // Next step: fall through, or jump where the condition holds.
    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = STEP_FIRST;
            busy_next = 1'b1;
        end
        else if (advance)
        begin
            case (ctrl.jmp)
                JMP_NONE:     pc_next = pc_reg + step_t'(1);
                JMP_NO_PARAM: pc_next = cond.no_param ? ctrl.target : pc_reg + step_t'(1);
                JMP_NO_HI:    pc_next = cond.no_hi ? ctrl.target : pc_reg + step_t'(1);
                JMP_END:
                begin
                    if (cond.more)
                    begin
                        pc_next = ctrl.target;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:      pc_next = pc_reg + step_t'(1);
            endcase
        end
    end

    // Step counter and run flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_FIRST;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== hw/rtl/servo_command_packet_framer_top.sv =====
// Top level of the servo command packet framer.
// Depends on svcf_pkg, the interfaces in svcf_intf.sv and the sequencer svcf_seq.

// Takes one servo command item and sends its serial packet as a stream of byte items:
// FF FF id length instruction parameters checksum, the checksum being the inverted 8-bit
// sum from id onward. Write and reset packets go out once or twice as the repeat register
// says (a value of 0 or 1 gives one copy, 2 or 3 gives two); read and ping go out once.
// A microcode sequencer steps through a nine-word program, one step and one byte a cycle,
// and a command has 6 to 18 bytes; the output register only holds the sequencer back
// while the sink stalls. Commands are taken one at a time. The repeat register is
// sampled when a command is accepted.
module servo_command_packet_framer_top
    import svcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    svcf_cmd_if.sink   cmd,
    svcf_byte_if.source tx,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data
);

    logic [1:0]  repeats_reg;
    logic [1:0]  func_reg;
    logic [7:0]  id_reg;
    logic [7:0]  addr_reg;
    logic [15:0] value_reg;
    logic [1:0]  cnt_reg;
    logic        more_reg;
    logic        more_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;
    logic        out_last_reg;

    logic        busy;
    logic        start;
    logic        advance;
    ctrl_word_t  ctrl;
    cond_t       cond;
    logic [7:0]  step_byte;
    logic [7:0]  len_byte;
    logic [7:0]  ins_byte;
    logic        is_write;

    // Handshake: take a command when idle, step whenever the output slot frees.
    assign start   = cmd.valid && !busy;
    assign cmd.ready = !busy;
    assign advance = busy && (!out_valid_reg || tx.ready);

    assign tx.valid     = out_valid_reg;
    assign tx.tx_byte   = out_byte_reg;
    assign tx.frame_end = out_end_reg;
    assign tx.last      = out_last_reg;

    // Repeat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeats_reg <= 2'd2;
        end
        else if (cfg_we)
        begin
            repeats_reg <= cfg_data;
        end
    end

    // Conditions for the sequencer's jumps.
    assign is_write      = (func_reg == FUNC_WRITE);
    assign cond.no_param = (func_reg == FUNC_PING) || (func_reg == FUNC_RESET);
    assign cond.no_hi    = !(is_write && (cnt_reg == CNT_TWO));
    assign cond.more     = more_reg;

    svcf_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .advance (advance),
        .cond    (cond),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    // Length and instruction bytes of the command held.
    always_comb
    begin
        case (func_reg)
            FUNC_WRITE:
            begin
                len_byte = (cnt_reg == CNT_TWO) ? LEN_LONG : LEN_MID;
                ins_byte = INS_WRITE;
            end
            FUNC_READ:
            begin
                len_byte = LEN_MID;
                ins_byte = INS_READ;
            end
            FUNC_PING:
            begin
                len_byte = LEN_SHORT;
                ins_byte = INS_PING;
            end
            default:
            begin
                len_byte = LEN_SHORT;
                ins_byte = INS_RESET;
            end
        endcase
    end

    // Byte selected by the current control word.
    always_comb
    begin
        case (ctrl.src)
            SRC_HDR:  step_byte = HDR_BYTE;
            SRC_ID:   step_byte = id_reg;
            SRC_LEN:  step_byte = len_byte;
            SRC_INS:  step_byte = ins_byte;
            SRC_ADDR: step_byte = addr_reg;
            SRC_P1:   step_byte = is_write ? value_reg[7:0] : {6'd0, cnt_reg};
            SRC_HI:   step_byte = value_reg[15:8];
            SRC_CHK:  step_byte = ~sum_reg;
            default:  step_byte = HDR_BYTE;
        endcase
    end

    // Checksum and copy bookkeeping.
    always_comb
    begin
        sum_next  = sum_reg;
        more_next = more_reg;
        if (start)
        begin
            sum_next  = 8'd0;
            more_next = ((cmd.func == FUNC_WRITE) || (cmd.func == FUNC_RESET)) && repeats_reg[1];
        end
        else if (advance)
        begin
            if (ctrl.chk)
            begin
                sum_next  = 8'd0;
                more_next = 1'b0;
            end
            else if (ctrl.add_sum)
            begin
                sum_next = sum_reg + step_byte;
            end
        end
    end

    // Output slot state.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            more_reg      <= more_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command fields and running checksum.
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (start)
        begin
            func_reg  <= cmd.func;
            id_reg    <= cmd.servo_id;
            addr_reg  <= cmd.reg_addr;
            value_reg <= cmd.value;
            cnt_reg   <= cmd.byte_count;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= step_byte;
            out_end_reg  <= ctrl.chk;
            out_last_reg <= ctrl.chk && !more_reg;
        end
    end

endmodule
